[rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and types for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PG_W       = $clog2(MAX_PAGES + 1);   // page count width
    localparam int IDX_W      = $clog2(MAX_PAGES);       // map index width
    localparam int OFS_W      = $clog2(PAGE_BYTES);      // byte offset width
    localparam int BIG_W      = 33 - OFS_W;              // rounded page count width

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_REALLOC = 2'd2;
    localparam logic [1:0] ACT_STAT    = 2'd3;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // Map access request from the sequencer to the map memory
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [IDX_W-1:0] addr;
        logic             wdata;
    } t_map_req;

    // ceil(bytes / PAGE_BYTES), no wrap
    function automatic logic [BIG_W-1:0] bytes_to_pages(input logic [31:0] b);
        logic [BIG_W-1:0] q;
        q = {1'b0, b[31:OFS_W]};
        return q + {{(BIG_W-1){1'b0}}, |b[OFS_W-1:0]};
    endfunction

endpackage

[rtl/bpa_map_ram.sv]
// ----------------------------------------------------------------------------
// bpa_map_ram
// Page used map: one bit per page, one read or write port, registered read.
// ----------------------------------------------------------------------------
module bpa_map_ram
    import bpa_pkg::*;
(
    input  logic     i_clk,
    input  t_map_req i_req,
    output logic     o_rdata
);

    logic r_mem [MAX_PAGES];
    logic r_rdata;

    // Synchronous read and write
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bitmap_page_allocator_core.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page allocator over a one-bit-per-page used map in a RAM.
// ----------------------------------------------------------------------------
// Flow: accept, decode in ST_DEC, the map walk, then ST_OUT loads the result.
// Alloc probes each page with a read (ST_SCAN), then a check (ST_SCHK), plus
// one write per marked page. Free and shrink write each page in ST_CLR;
// in-place grow reads and checks each page; stat reads and counts each page.
// One item at a time; the next is accepted once the result is taken. Sync
// active-low reset sets control and config to defaults, then clears every map page.
module bitmap_page_allocator_core
    import bpa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,   // [1:0] action, [33:2] address,
                                          // [65:34] size, [97:66] new_size
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [55:0]   m_axis_tdata    // [31:0] result_address, [32] ok,
                                          // [33] moved, [44:34] managed_pages,
                                          // [55:45] free_pages
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;   // alloc search, issue read
    localparam logic [3:0] ST_SCHK  = 4'd4;   // alloc search, check data
    localparam logic [3:0] ST_MARK  = 4'd5;   // write used bits
    localparam logic [3:0] ST_CLR   = 4'd6;   // clear bits
    localparam logic [3:0] ST_GROW  = 4'd7;   // in-place check, issue read
    localparam logic [3:0] ST_GCHK  = 4'd8;
    localparam logic [3:0] ST_STAT  = 4'd9;
    localparam logic [3:0] ST_SCNT  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]       r_state;
    logic [31:0]      r_base, r_end;
    logic [PG_W-1:0]  r_cnt_cfg;
    logic [1:0]       r_act;
    logic [31:0]      r_addr, r_size, r_nsize;
    logic [BIG_W-1:0] r_need;        // pages wanted by the search
    logic [PG_W:0]    r_s, r_p;      // run start, probe index
    logic [BIG_W-1:0] r_cend;        // end of clear/mark run (exclusive)
    logic             r_grow;        // mark is in-place grow
    logic [PG_W-1:0]  r_free;
    logic [55:0]      r_out;
    logic             r_ovalid;
    logic             rdata;
    t_map_req         req;

    logic [PG_W-1:0]  live;
    logic [BIG_W-1:0] opg, npg, apg;
    logic [31:0]      rel;
    logic [BIG_W-1:0] start;
    logic             free_ok;

    assign live  = (r_cnt_cfg > PG_W'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : r_cnt_cfg;
    assign opg   = bytes_to_pages(r_size);
    assign npg   = bytes_to_pages(r_nsize);
    assign rel   = r_addr - r_base;
    assign start = {1'b0, rel[31:OFS_W]};
    assign free_ok = (r_addr >= r_base) && (r_addr < r_end) && (opg != '0) &&
                     (start < BIG_W'(live));
    assign apg   = (r_act == ACT_ALLOC) ? opg : npg;

    bpa_map_ram u_map (.i_clk(i_clk), .i_req(req), .o_rdata(rdata));

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // Map port drive
    always_comb begin
        req = '0;
        case (r_state)
            ST_CLEAR: begin
                req.wr = 1'b1; req.addr = r_p[IDX_W-1:0]; req.wdata = 1'b0;
            end
            ST_SCAN, ST_GROW, ST_STAT: begin
                req.rd = 1'b1; req.addr = r_p[IDX_W-1:0];
            end
            ST_MARK: begin
                req.wr = 1'b1; req.addr = r_p[IDX_W-1:0]; req.wdata = 1'b1;
            end
            ST_CLR: begin
                req.wr = (r_p < (PG_W+1)'(live)) && ({{(BIG_W-PG_W-1){1'b0}}, r_p} < r_cend);
                req.addr = r_p[IDX_W-1:0]; req.wdata = 1'b0;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_base    <= '0;
            r_end     <= 32'h0040_0000;
            r_cnt_cfg <= PG_W'(1024);
            r_ovalid  <= 1'b0;
            r_p       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:  r_base    <= i_cfg_wdata;
                    CFG_END:   r_end     <= i_cfg_wdata;
                    CFG_COUNT: r_cnt_cfg <= i_cfg_wdata[PG_W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_p <= r_p + 1'b1;
                    if (r_p == (PG_W+1)'(MAX_PAGES - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act   <= s_axis_tdata[1:0];
                        r_addr  <= s_axis_tdata[33:2];
                        r_size  <= s_axis_tdata[65:34];
                        r_nsize <= s_axis_tdata[97:66];
                        r_out   <= '0;
                        r_free  <= '0;
                        r_grow  <= 1'b0;
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_state <= ST_OUT;
                    case (r_act)
                        ACT_STAT: begin
                            r_p <= '0;
                            r_out[44:34] <= 11'(live);
                            if (live != '0) r_state <= ST_STAT;
                        end
                        ACT_FREE: begin
                            r_p <= (PG_W+1)'(start);
                            r_cend <= start + opg;
                            if (free_ok) r_state <= ST_CLR;
                        end
                        default: begin
                            if (r_act == ACT_REALLOC && r_addr != '0) begin
                                if (r_nsize == '0) begin
                                    r_p <= (PG_W+1)'(start);
                                    r_cend <= start + opg;
                                    if (free_ok) r_state <= ST_CLR;
                                end else if (npg <= opg) begin
                                    r_out[31:0] <= r_addr;
                                    r_out[32]   <= 1'b1;
                                    r_p <= (PG_W+1)'(start + npg);
                                    r_cend <= start + opg;
                                    if (start + npg < BIG_W'(live)) r_state <= ST_CLR;
                                end else if ((start + opg <= BIG_W'(live)) &&
                                             (npg - opg <= BIG_W'(live) - (start + opg))) begin
                                    r_p <= (PG_W+1)'(start + opg);
                                    r_s <= (PG_W+1)'(start + opg);
                                    r_cend <= start + npg;
                                    r_state <= ST_GROW;
                                end else begin
                                    r_need <= npg; r_s <= '0; r_p <= '0;
                                    r_state <= (npg > BIG_W'(live)) ? ST_OUT : ST_SCAN;
                                end
                            end else begin
                                // plain alloc of size or new_size
                                r_need <= apg; r_s <= '0; r_p <= '0;
                                if (apg == '0) begin
                                    r_out[31:0] <= r_base;
                                    r_out[32]   <= 1'b1;
                                end else if (apg <= BIG_W'(live)) begin
                                    r_state <= ST_SCAN;
                                end
                            end
                        end
                    endcase
                end
                ST_GROW: r_state <= ST_GCHK;
                ST_GCHK: begin
                    if (rdata) begin
                        // fall back to a full allocation elsewhere
                        r_need <= npg; r_s <= '0; r_p <= '0;
                        r_state <= (npg > BIG_W'(live)) ? ST_OUT : ST_SCAN;
                    end else if ({{(BIG_W-PG_W-1){1'b0}}, r_p} + 1'b1 == r_cend) begin
                        r_p <= r_s; r_grow <= 1'b1; r_state <= ST_MARK;
                    end else begin
                        r_p <= r_p + 1'b1; r_state <= ST_GROW;
                    end
                end
                ST_SCAN: r_state <= ST_SCHK;
                ST_SCHK: begin
                    if (rdata) begin
                        if ({{(BIG_W-PG_W-1){1'b0}}, r_p} + 1'b1 + r_need > BIG_W'(live)) begin
                            r_state <= ST_OUT;   // no run fits
                        end else begin
                            r_s <= r_p + 1'b1; r_p <= r_p + 1'b1; r_state <= ST_SCAN;
                        end
                    end else if ({{(BIG_W-PG_W-1){1'b0}}, r_p} + 1'b1 ==
                                 {{(BIG_W-PG_W-1){1'b0}}, r_s} + r_need) begin
                        r_cend <= {{(BIG_W-PG_W-1){1'b0}}, r_s} + r_need;
                        r_p <= r_s; r_state <= ST_MARK;
                    end else begin
                        r_p <= r_p + 1'b1; r_state <= ST_SCAN;
                    end
                end
                ST_MARK: begin
                    if ({{(BIG_W-PG_W-1){1'b0}}, r_p} + 1'b1 == r_cend) begin
                        r_out[32] <= 1'b1;
                        if (r_grow) begin
                            r_out[31:0] <= r_addr;
                            r_state <= ST_OUT;
                        end else begin
                            r_out[31:0] <= r_base + {{(32-OFS_W-PG_W-1){1'b0}}, r_s,
                                                     {OFS_W{1'b0}}};
                            if (r_act == ACT_REALLOC && r_addr != '0) begin
                                r_out[33] <= 1'b1;
                                r_p <= (PG_W+1)'(start);
                                r_cend <= start + opg;
                                r_state <= free_ok ? ST_CLR : ST_OUT;
                            end else begin
                                r_state <= ST_OUT;
                            end
                        end
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                ST_CLR: begin
                    if (r_p + 1'b1 >= (PG_W+1)'(live) ||
                        {{(BIG_W-PG_W-1){1'b0}}, r_p} + 1'b1 >= r_cend)
                        r_state <= ST_OUT;
                    else
                        r_p <= r_p + 1'b1;
                end
                ST_STAT: r_state <= ST_SCNT;
                ST_SCNT: begin
                    if (!rdata) r_free <= r_free + 1'b1;
                    if (r_p + 1'b1 == (PG_W+1)'(live)) begin
                        r_out[55:45] <= 11'(r_free + PG_W'(!rdata));
                        r_state <= ST_OUT;
                    end else begin
                        r_p <= r_p + 1'b1; r_state <= ST_STAT;
                    end
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the bitmap page allocator: a shadow page map predicts each
// result, random requests run against several region settings, and both
// stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb
    import bpa_pkg::*;
;

    typedef struct packed {
        logic [31:0] new_size;
        logic [31:0] size;
        logic [31:0] address;
        logic [1:0]  action;
    } t_req;

    typedef struct packed {
        logic [10:0] free_pages;
        logic [10:0] managed_pages;
        logic        moved;
        logic        ok;
        logic [31:0] result_address;
    } t_rsp;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_wdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [55:0]   m_axis_tdata;

    bitmap_page_allocator_core i_dut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow state
    logic [31:0] sh_base, sh_end;
    logic [10:0] sh_count;
    bit          sh_map[MAX_PAGES];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   mismatches = 0;
    bit   calm = 1'b0;
    int   src_idle = 0, snk_idle = 0;

    function automatic longint live_pages();
        return (sh_count < MAX_PAGES) ? longint'(sh_count) : longint'(MAX_PAGES);
    endfunction

    function automatic longint pages_of(logic [31:0] b);
        return longint'(b) / PAGE_BYTES + ((b % PAGE_BYTES) != 0);
    endfunction

    function automatic logic [31:0] addr_of(longint idx);
        logic [31:0] ofs;
        ofs = 32'(idx * PAGE_BYTES);
        return sh_base + ofs;
    endfunction

    function automatic bit reserve_run(longint start, longint cnt);
        longint n;
        n = live_pages();
        if (start > n || cnt > n - start) return 0;
        for (longint i = 0; i < cnt; i++) if (sh_map[start + i]) return 0;
        for (longint i = 0; i < cnt; i++) sh_map[start + i] = 1;
        return 1;
    endfunction

    function automatic void clear_run(longint start, longint cnt);
        longint n;
        n = live_pages();
        for (longint i = 0; i < cnt; i++) begin
            if (start + i >= n) break;
            sh_map[start + i] = 0;
        end
    endfunction

    function automatic bit first_fit(logic [31:0] bytes, output logic [31:0] a);
        longint need, n;
        need = pages_of(bytes);
        n = live_pages();
        a = '0;
        if (need == 0) begin
            a = sh_base;
            return 1;
        end
        if (need > n) return 0;
        for (longint s = 0; s + need <= n; s++) begin
            if (reserve_run(s, need)) begin
                a = addr_of(s);
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void release_block(logic [31:0] a, logic [31:0] bytes);
        logic [31:0] d;
        if (a < sh_base || a >= sh_end || pages_of(bytes) == 0) return;
        d = (a - sh_base) / PAGE_BYTES;
        clear_run(longint'(d), pages_of(bytes));
    endfunction

    function automatic t_rsp predict_alloc(t_req r);
        t_rsp o;
        logic [31:0] a;
        longint opg, npg, st;
        logic [31:0] d;
        o = '0;
        a = '0;
        case (r.action)
            ACT_ALLOC: o.ok = first_fit(r.size, a);
            ACT_FREE: release_block(r.address, r.size);
            ACT_REALLOC: begin
                if (r.address == 0) begin
                    o.ok = first_fit(r.new_size, a);
                end else if (r.new_size == 0) begin
                    release_block(r.address, r.size);
                end else begin
                    opg = pages_of(r.size);
                    npg = pages_of(r.new_size);
                    d = (r.address - sh_base) / PAGE_BYTES;
                    st = longint'(d);
                    if (npg <= opg) begin
                        clear_run(st + npg, opg - npg);
                        a = r.address;
                        o.ok = 1;
                    end else if (reserve_run(st + opg, npg - opg)) begin
                        a = r.address;
                        o.ok = 1;
                    end else if (first_fit(r.new_size, a)) begin
                        release_block(r.address, r.size);
                        o.ok = 1;
                        o.moved = 1;
                    end
                end
            end
            default: begin
                o.managed_pages = 11'(live_pages());
                for (longint i = 0; i < live_pages(); i++)
                    if (!sh_map[i]) o.free_pages++;
            end
        endcase
        o.result_address = o.ok ? a : '0;
        return o;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                src_idle <= $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                expected_rsps.push_back(predict_alloc(r));
                s_axis_tdata <= {6'b0, r};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_rsp got, exp_rsp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (got !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp addr %h ok %b mv %b tot %0d free %0d",
                            exp_rsp.result_address, exp_rsp.ok, exp_rsp.moved,
                            exp_rsp.managed_pages, exp_rsp.free_pages);
                        $display("          got addr %h ok %b mv %b tot %0d free %0d",
                            got.result_address, got.ok, got.moved,
                            got.managed_pages, got.free_pages);
                    end
                end
            end
        end
        if (snk_idle > 0) begin
            snk_idle <= snk_idle - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            snk_idle <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BASE: sh_base = val;
            CFG_END:  sh_end = val;
            default:  sh_count = val[10:0];
        endcase
    endtask

    task automatic push_req(logic [1:0] act, logic [31:0] a, logic [31:0] sz,
                            logic [31:0] nsz);
        t_req r;
        r.action = act;
        r.address = a;
        r.size = sz;
        r.new_size = nsz;
        pending_reqs.push_back(r);
    endtask

    // Wait until every queued item has gone and every result has come back
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_bytes(int maxpg);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, maxpg * PAGE_BYTES);
        endcase
    endfunction

    // Well-formed mix around the live blocks, plus noise
    task automatic random_phase(int n, int maxpg);
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            a = sh_base + PAGE_BYTES * $urandom_range(0, 1100);
            if ($urandom_range(0, 9) == 0) a = $urandom();
            if ($urandom_range(0, 15) == 0) a = 32'd0;
            if ($urandom_range(0, 30) == 0) a = a + $urandom_range(1, PAGE_BYTES - 1);
            case ($urandom_range(0, 9))
                0, 1, 2: push_req(ACT_ALLOC, $urandom(), rand_bytes(maxpg), $urandom());
                3, 4, 5: push_req(ACT_FREE, a, rand_bytes(maxpg), $urandom());
                6, 7, 8: push_req(ACT_REALLOC, a, rand_bytes(maxpg), rand_bytes(maxpg));
                default: push_req(ACT_STAT, $urandom(), $urandom(), $urandom());
            endcase
        end
    endtask

    initial begin
        sh_base = 0;
        sh_end = 32'h0040_0000;
        sh_count = 11'd1024;
        foreach (sh_map[i]) sh_map[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edges of sizes and every realloc case
        push_req(ACT_STAT, 0, 0, 0);
        push_req(ACT_ALLOC, 0, 0, 0);
        push_req(ACT_ALLOC, 0, 1, 0);
        push_req(ACT_ALLOC, 0, PAGE_BYTES, 0);
        push_req(ACT_ALLOC, 0, PAGE_BYTES + 1, 0);
        push_req(ACT_ALLOC, 0, 32'hFFFF_FFFF, 0);
        push_req(ACT_REALLOC, 0, 0, 3 * PAGE_BYTES);
        push_req(ACT_REALLOC, 32'h1000, PAGE_BYTES, PAGE_BYTES);
        push_req(ACT_REALLOC, 32'h1000, PAGE_BYTES, 2 * PAGE_BYTES);
        push_req(ACT_REALLOC, 32'h1000, 2 * PAGE_BYTES, 1);
        push_req(ACT_REALLOC, 32'h0, PAGE_BYTES, 5 * PAGE_BYTES);
        push_req(ACT_REALLOC, 32'h1000, PAGE_BYTES, 8 * PAGE_BYTES);
        push_req(ACT_REALLOC, 32'h3000, PAGE_BYTES, 0);
        push_req(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push_req(ACT_FREE, 32'h0, 0, 0);
        push_req(ACT_FREE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(ACT_ALLOC, 0, 1024 * PAGE_BYTES, 0);
        push_req(ACT_ALLOC, 0, 1, 0);
        push_req(ACT_REALLOC, 32'h5000, 1, 32'hFFFF_FFFF);
        push_req(ACT_STAT, 32'hFFFF_FFFF, 0, 0);
        push_req(ACT_FREE, 32'h0, 1024 * PAGE_BYTES, 0);
        drain();

        // Small region with a high base, end below the top of the pages
        cfg_write(CFG_BASE, 32'hFFFF_8000);
        cfg_write(CFG_END, 32'hFFFF_F000);
        cfg_write(CFG_COUNT, 32'd12);
        random_phase(300, 6);
        drain();

        // Zero pages managed
        cfg_write(CFG_BASE, 32'h0000_0000);
        cfg_write(CFG_END, 32'h0);
        cfg_write(CFG_COUNT, 32'd0);
        random_phase(40, 3);
        drain();

        // Count over the map size, widest end
        cfg_write(CFG_BASE, 32'h1234_5000);
        cfg_write(CFG_END, 32'hFFFF_FFFF);
        cfg_write(CFG_COUNT, 32'h7FF);
        random_phase(300, 200);
        drain();

        // Medium region, calm tail
        cfg_write(CFG_BASE, 32'h0010_0000);
        cfg_write(CFG_END, 32'h0014_0000);
        cfg_write(CFG_COUNT, 32'd64);
        random_phase(400, 20);
        while (pending_reqs.size() > 200) @(posedge i_clk);
        calm = 1'b1;
        random_phase(260, 20);
        drain();
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #500ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
